// File: rtl/tu3_pkg.sv
// Shared constants, types and the job format for the trilinear 2x upsampler.
package tu3_pkg;

  localparam int MaxExtent    = 16;
  localparam int CoordBits    = 4;
  localparam int ChildBits    = 5;
  localparam int ExtentBits   = 5;
  localparam int ValueWidth   = 32;
  localparam int HalfBits     = CoordBits - 1;
  localparam int BankAddrBits = 3 * HalfBits;
  localparam int BankDepth    = 2 ** BankAddrBits;
  localparam int NumBanks     = 8;
  localparam int BankSelBits  = 3;
  localparam int PairWidth    = ValueWidth + 1;
  localparam int SumWidth     = ValueWidth + 3;
  localparam int ShiftBits    = 2;
  localparam int QueueDepth   = 2;
  localparam int QueuePtrBits = 1;
  localparam int CountBits    = $clog2(QueueDepth + 1);
  localparam int CfgIndexBits = 2;

  localparam logic [CfgIndexBits-1:0] CfgExtentX = 2'd0;
  localparam logic [CfgIndexBits-1:0] CfgExtentY = 2'd1;
  localparam logic [CfgIndexBits-1:0] CfgExtentZ = 2'd2;

  localparam logic [ExtentBits-1:0] ExtentReset   = ExtentBits'(16);
  localparam logic [ExtentBits-1:0] MaxExtentCode = ExtentBits'(MaxExtent);

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_FLAG
  } op_t;

  typedef logic [BankAddrBits-1:0]       bank_addr_t;
  typedef logic signed [ValueWidth-1:0]  value_t;

  typedef struct packed {
    op_t                              op;
    logic [BankSelBits-1:0]           wr_bank;
    bank_addr_t                       wr_addr;
    value_t                           wr_value;
    logic [NumBanks-1:0]              rd_en;
    logic [NumBanks-1:0][BankAddrBits-1:0] rd_addr;
    logic [ShiftBits-1:0]             shift;
  } job_t;

endpackage

// File: rtl/tu3_bank.sv
// One parity bank of the parent store: one write port and one registered read port.
module tu3_bank (
  input  logic                 clk,
  input  logic                 we,
  input  tu3_pkg::bank_addr_t  waddr,
  input  tu3_pkg::value_t      wdata,
  input  logic                 re,
  input  tu3_pkg::bank_addr_t  raddr,
  output tu3_pkg::value_t      rdata
);

  tu3_pkg::value_t mem [tu3_pkg::BankDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tu3_queue.sv
// Short job queue between the classifying front end and the back end.
module tu3_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tu3_pkg::job_t  in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output tu3_pkg::job_t  out_job
);

  tu3_pkg::job_t                      slots [tu3_pkg::QueueDepth];
  logic [tu3_pkg::QueuePtrBits-1:0]   wr_ptr;
  logic [tu3_pkg::QueuePtrBits-1:0]   rd_ptr;
  logic [tu3_pkg::CountBits-1:0]      count;
  logic                               push;
  logic                               pop;

  assign in_ready  = (count != tu3_pkg::CountBits'(tu3_pkg::QueueDepth));
  assign out_valid = (count != '0);
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tu3_front.sv
// Front end: extent registers, item classification and bank address generation.
module tu3_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tu3_pkg::CfgIndexBits-1:0]      cfg_index,
  input  logic [tu3_pkg::ExtentBits-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic [tu3_pkg::CoordBits-1:0]         parent_x,
  input  logic [tu3_pkg::CoordBits-1:0]         parent_y,
  input  logic [tu3_pkg::CoordBits-1:0]         parent_z,
  input  tu3_pkg::value_t                       parent_value,
  input  logic [tu3_pkg::ChildBits-1:0]         child_x,
  input  logic [tu3_pkg::ChildBits-1:0]         child_y,
  input  logic [tu3_pkg::ChildBits-1:0]         child_z,
  output logic                                  job_valid,
  input  logic                                  job_ready,
  output tu3_pkg::job_t                         job
);

  logic [tu3_pkg::ExtentBits-1:0] extent_x;
  logic [tu3_pkg::ExtentBits-1:0] extent_y;
  logic [tu3_pkg::ExtentBits-1:0] extent_z;
  logic [tu3_pkg::ExtentBits-1:0] eff_x;
  logic [tu3_pkg::ExtentBits-1:0] eff_y;
  logic [tu3_pkg::ExtentBits-1:0] eff_z;
  logic                           ok_x;
  logic                           ok_y;
  logic                           ok_z;
  logic [tu3_pkg::CoordBits-1:0]  x0;
  logic [tu3_pkg::CoordBits-1:0]  y0;
  logic [tu3_pkg::CoordBits-1:0]  z0;
  logic                           dx;
  logic                           dy;
  logic                           dz;

  function automatic logic [tu3_pkg::ExtentBits-1:0] clamp_extent(
    input logic [tu3_pkg::ExtentBits-1:0] e
  );
    return (e > tu3_pkg::MaxExtentCode) ? tu3_pkg::MaxExtentCode : e;
  endfunction

  function automatic logic axis_ok(
    input logic [tu3_pkg::ChildBits-1:0]  c,
    input logic [tu3_pkg::ExtentBits-1:0] e
  );
    return (c != '0) && ({1'b0, c} < {e, 1'b0});
  endfunction

  // Returns whether this parity is used on the axis, then the half coordinate.
  function automatic logic [tu3_pkg::HalfBits:0] axis_sel(
    input logic [tu3_pkg::CoordBits-1:0] p0,
    input logic                          d,
    input logic                          par
  );
    logic                          match;
    logic [tu3_pkg::CoordBits-1:0] coord;
    match = (p0[0] == par);
    coord = match ? p0 : p0 + tu3_pkg::CoordBits'(1);
    return {match | d, coord[tu3_pkg::CoordBits-1:1]};
  endfunction

  assign cfg_ready = 1'b1;
  assign job_valid = in_valid;
  assign in_ready  = job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_x <= tu3_pkg::ExtentReset;
      extent_y <= tu3_pkg::ExtentReset;
      extent_z <= tu3_pkg::ExtentReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tu3_pkg::CfgExtentX: extent_x <= cfg_data;
        tu3_pkg::CfgExtentY: extent_y <= cfg_data;
        tu3_pkg::CfgExtentZ: extent_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_x = clamp_extent(extent_x);
  assign eff_y = clamp_extent(extent_y);
  assign eff_z = clamp_extent(extent_z);
  assign ok_x  = axis_ok(child_x, eff_x);
  assign ok_y  = axis_ok(child_y, eff_y);
  assign ok_z  = axis_ok(child_z, eff_z);

  always_comb begin
    logic [tu3_pkg::ChildBits-1:0] mx;
    logic [tu3_pkg::ChildBits-1:0] my;
    logic [tu3_pkg::ChildBits-1:0] mz;
    mx = child_x - tu3_pkg::ChildBits'(1);
    my = child_y - tu3_pkg::ChildBits'(1);
    mz = child_z - tu3_pkg::ChildBits'(1);
    x0 = mx[tu3_pkg::ChildBits-1:1];
    y0 = my[tu3_pkg::ChildBits-1:1];
    z0 = mz[tu3_pkg::ChildBits-1:1];
    dx = ~child_x[0];
    dy = ~child_y[0];
    dz = ~child_z[0];
  end

  always_comb begin
    logic [tu3_pkg::HalfBits:0] sx;
    logic [tu3_pkg::HalfBits:0] sy;
    logic [tu3_pkg::HalfBits:0] sz;
    job          = '0;
    job.wr_bank  = {parent_z[0], parent_y[0], parent_x[0]};
    job.wr_addr  = {parent_z[tu3_pkg::CoordBits-1:1], parent_y[tu3_pkg::CoordBits-1:1],
                    parent_x[tu3_pkg::CoordBits-1:1]};
    job.wr_value = parent_value;
    job.shift    = tu3_pkg::ShiftBits'(dx) + tu3_pkg::ShiftBits'(dy) +
                   tu3_pkg::ShiftBits'(dz);
    for (int b = 0; b < tu3_pkg::NumBanks; b++) begin
      sx = axis_sel(x0, dx, b[0]);
      sy = axis_sel(y0, dy, b[1]);
      sz = axis_sel(z0, dz, b[2]);
      job.rd_en[b]   = sx[tu3_pkg::HalfBits] & sy[tu3_pkg::HalfBits] & sz[tu3_pkg::HalfBits];
      job.rd_addr[b] = {sz[tu3_pkg::HalfBits-1:0], sy[tu3_pkg::HalfBits-1:0],
                        sx[tu3_pkg::HalfBits-1:0]};
    end
    if (!kind) begin
      job.op = tu3_pkg::OP_WRITE;
    end else if (ok_x && ok_y && ok_z) begin
      job.op = tu3_pkg::OP_READ;
    end else begin
      job.op = tu3_pkg::OP_FLAG;
    end
  end

endmodule

// File: rtl/tu3_back.sv
// Back end: parity-banked parent store, corner fetch, summation and output register.
module tu3_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  tu3_pkg::job_t         job,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tu3_pkg::value_t       child_value,
  output logic                  out_of_range
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SUM,
    S_FLAG
  } state_t;

  state_t                                       state;
  logic                                         take;
  logic                                         slot_free;
  logic                                         emit;
  logic [tu3_pkg::NumBanks-1:0]                 bank_we;
  logic [tu3_pkg::NumBanks-1:0]                 bank_re;
  tu3_pkg::value_t                              bank_data [tu3_pkg::NumBanks];
  logic [tu3_pkg::NumBanks-1:0]                 rd_en;
  logic [tu3_pkg::ShiftBits-1:0]                shift;
  logic [3:0][tu3_pkg::PairWidth-1:0]           pair;
  logic [3:0][tu3_pkg::PairWidth-1:0]           pair_next;
  logic signed [tu3_pkg::SumWidth-1:0]          total;
  logic signed [tu3_pkg::SumWidth-1:0]          shifted;

  assign job_ready = (state == S_IDLE);
  assign take      = job_valid && job_ready;
  assign slot_free = !out_valid || out_ready;
  assign emit      = ((state == S_SUM) || (state == S_FLAG)) && slot_free;

  for (genvar b = 0; b < tu3_pkg::NumBanks; b++) begin : g_bank
    assign bank_we[b] = take && (job.op == tu3_pkg::OP_WRITE) &&
                        (job.wr_bank == tu3_pkg::BankSelBits'(b));
    assign bank_re[b] = take && (job.op == tu3_pkg::OP_READ) && job.rd_en[b];

    tu3_bank u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (job.wr_addr),
      .wdata (job.wr_value),
      .re    (bank_re[b]),
      .raddr (job.rd_addr[b]),
      .rdata (bank_data[b])
    );
  end

  always_comb begin
    logic [tu3_pkg::PairWidth-1:0] lo;
    logic [tu3_pkg::PairWidth-1:0] hi;
    for (int k = 0; k < 4; k++) begin
      lo = rd_en[2*k] ?
           {bank_data[2*k][tu3_pkg::ValueWidth-1], bank_data[2*k]} : '0;
      hi = rd_en[2*k+1] ?
           {bank_data[2*k+1][tu3_pkg::ValueWidth-1], bank_data[2*k+1]} : '0;
      pair_next[k] = lo + hi;
    end
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < 4; k++) begin
      total = total + {{2{pair[k][tu3_pkg::PairWidth-1]}}, pair[k]};
    end
    shifted = total >>> shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (job.op)
              tu3_pkg::OP_READ: begin
                rd_en <= job.rd_en;
                shift <= job.shift;
                state <= S_FETCH;
              end
              tu3_pkg::OP_FLAG: begin
                state <= S_FLAG;
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          pair  <= pair_next;
          state <= S_SUM;
        end
        S_SUM: begin
          if (slot_free) begin
            child_value  <= shifted[tu3_pkg::ValueWidth-1:0];
            out_of_range <= 1'b0;
            state        <= S_IDLE;
          end
        end
        S_FLAG: begin
          if (slot_free) begin
            child_value  <= '0;
            out_of_range <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/trilinear_upsample_2x_3d.sv
// Top level of the trilinear 2x upsampler: front end, job queue and banked back end.
// A write item passes the job queue and is written into its bank when the back end takes it;
// writes sustain one per cycle while the back end is idle. A read item passes the bank read, the
// pair adders and the final sum and shift; no new job is taken until its result is registered.
// Reset sets every extent to 16 and empties the queue; the parent store is not cleared.
module trilinear_upsample_2x_3d (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tu3_pkg::CfgIndexBits-1:0]      cfg_index,
  input  logic [tu3_pkg::ExtentBits-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic [tu3_pkg::CoordBits-1:0]         parent_x,
  input  logic [tu3_pkg::CoordBits-1:0]         parent_y,
  input  logic [tu3_pkg::CoordBits-1:0]         parent_z,
  input  logic signed [tu3_pkg::ValueWidth-1:0] parent_value,
  input  logic [tu3_pkg::ChildBits-1:0]         child_x,
  input  logic [tu3_pkg::ChildBits-1:0]         child_y,
  input  logic [tu3_pkg::ChildBits-1:0]         child_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tu3_pkg::ValueWidth-1:0] child_value,
  output logic                                  out_of_range
);

  logic           fq_valid;
  logic           fq_ready;
  tu3_pkg::job_t  fq_job;
  logic           qb_valid;
  logic           qb_ready;
  tu3_pkg::job_t  qb_job;

  tu3_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .parent_x     (parent_x),
    .parent_y     (parent_y),
    .parent_z     (parent_z),
    .parent_value (parent_value),
    .child_x      (child_x),
    .child_y      (child_y),
    .child_z      (child_z),
    .job_valid    (fq_valid),
    .job_ready    (fq_ready),
    .job          (fq_job)
  );

  tu3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  tu3_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (qb_valid),
    .job_ready    (qb_ready),
    .job          (qb_job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .child_value  (child_value),
    .out_of_range (out_of_range)
  );

endmodule

// File: verif/trilinear_upsample_2x_3d_checker.sv
// Checker for the trilinear 2x upsampler: predicts each child result and compares it.
module trilinear_upsample_2x_3d_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [tu3_pkg::CfgIndexBits-1:0]      cfg_index,
  input  logic [tu3_pkg::ExtentBits-1:0]        cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  kind,
  input  logic [tu3_pkg::CoordBits-1:0]         parent_x,
  input  logic [tu3_pkg::CoordBits-1:0]         parent_y,
  input  logic [tu3_pkg::CoordBits-1:0]         parent_z,
  input  logic signed [tu3_pkg::ValueWidth-1:0] parent_value,
  input  logic [tu3_pkg::ChildBits-1:0]         child_x,
  input  logic [tu3_pkg::ChildBits-1:0]         child_y,
  input  logic [tu3_pkg::ChildBits-1:0]         child_z,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [tu3_pkg::ValueWidth-1:0] child_value,
  input  logic                                  out_of_range,
  output int unsigned                           mismatches,
  output int unsigned                           results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tu3_pkg::value_t value;
    logic            flag;
  } child_result_t;

  tu3_pkg::value_t                parent_nodes [tu3_pkg::MaxExtent**3];
  logic [tu3_pkg::ExtentBits-1:0] extent [3];
  child_result_t                  child_results_due [$];
  child_result_t                  oldest;

  function automatic child_result_t interpolate_child(
    input logic [tu3_pkg::ChildBits-1:0] cx,
    input logic [tu3_pkg::ChildBits-1:0] cy,
    input logic [tu3_pkg::ChildBits-1:0] cz);
    int                                   coord [3];
    int                                   lim [3];
    int                                   base [3];
    int                                   span [3];
    bit                                   in_patch;
    logic signed [tu3_pkg::SumWidth-1:0]  sum;
    logic signed [tu3_pkg::SumWidth-1:0]  term;
    child_result_t                        r;
    coord[0] = cx;
    coord[1] = cy;
    coord[2] = cz;
    in_patch = 1'b1;
    sum = '0;
    for (int a = 0; a < 3; a++) begin
      lim[a] = (extent[a] > tu3_pkg::MaxExtent) ? tu3_pkg::MaxExtent : int'(extent[a]);
      base[a] = 0;
      span[a] = 0;
      if (coord[a] < 1 || coord[a] + 1 > 2 * lim[a]) begin
        in_patch = 1'b0;
      end else begin
        base[a] = (coord[a] - 1) / 2;
        span[a] = (coord[a] % 2 == 0) ? 1 : 0;
      end
    end
    if (!in_patch) begin
      r.value = '0;
      r.flag = 1'b1;
      return r;
    end
    for (int i = 0; i <= span[0]; i++) begin
      for (int j = 0; j <= span[1]; j++) begin
        for (int k = 0; k <= span[2]; k++) begin
          term = parent_nodes[{4'(base[2] + k), 4'(base[1] + j), 4'(base[0] + i)}];
          sum = sum + term;
        end
      end
    end
    r.value = tu3_pkg::value_t'(sum >>> (span[0] + span[1] + span[2]));
    r.flag = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      extent[0] = tu3_pkg::ExtentReset;
      extent[1] = tu3_pkg::ExtentReset;
      extent[2] = tu3_pkg::ExtentReset;
      child_results_due.delete();
      results_outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (child_results_due.size() == 0) begin
          $error("child_value: expected none, actual %0d (out_of_range %0b)",
                 child_value, out_of_range);
          mismatches <= mismatches + 1;
        end else begin
          oldest = child_results_due.pop_front();
          if (child_value !== oldest.value || out_of_range !== oldest.flag) begin
            if (child_value !== oldest.value) begin
              $error("child_value: expected %0d, actual %0d", oldest.value, child_value);
            end
            if (out_of_range !== oldest.flag) begin
              $error("out_of_range: expected %0b, actual %0b", oldest.flag, out_of_range);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tu3_pkg::CfgExtentX: extent[0] = cfg_data;
          tu3_pkg::CfgExtentY: extent[1] = cfg_data;
          tu3_pkg::CfgExtentZ: extent[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (kind == 1'(tu3_pkg::OP_WRITE)) begin
          parent_nodes[{parent_z, parent_y, parent_x}] = parent_value;
        end else begin
          child_results_due = {child_results_due,
                               interpolate_child(child_x, child_y, child_z)};
        end
      end
      results_outstanding <= child_results_due.size();
    end
  end

endmodule

// File: verif/trilinear_upsample_2x_3d_tb.sv
// Testbench top for the trilinear 2x upsampler: clock, reset, stimulus and verdict.
module trilinear_upsample_2x_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LongStall     = 80;
  localparam int SettleCycles  = 8;
  localparam int DrainCycles   = 10;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseCount    = 7;
  localparam int ItemsPerPhase = 62;

  localparam logic [8*tu3_pkg::ValueWidth-1:0] CornerValues = {
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h0000_8000
  };

  logic                             clk;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [tu3_pkg::CfgIndexBits-1:0] cfg_index;
  logic [tu3_pkg::ExtentBits-1:0]   cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  logic                             kind;
  logic [tu3_pkg::CoordBits-1:0]    parent_x;
  logic [tu3_pkg::CoordBits-1:0]    parent_y;
  logic [tu3_pkg::CoordBits-1:0]    parent_z;
  tu3_pkg::value_t                  parent_value;
  logic [tu3_pkg::ChildBits-1:0]    child_x;
  logic [tu3_pkg::ChildBits-1:0]    child_y;
  logic [tu3_pkg::ChildBits-1:0]    child_z;
  logic                             out_valid;
  logic                             out_ready;
  tu3_pkg::value_t                  child_value;
  logic                             out_of_range;

  int unsigned mismatches;
  int unsigned results_outstanding;

  bit calm;
  bit stall_long;
  int idle_pct;
  int idle_cycles;
  int items_sent;
  int extent_set [3];
  bit node_written [tu3_pkg::MaxExtent**3];

  trilinear_upsample_2x_3d u_dut (.*);

  trilinear_upsample_2x_3d_checker u_checker (.*);

  always #1 clk = ~clk;

  function automatic int eff_extent(input int e);
    return (e > tu3_pkg::MaxExtent) ? tu3_pkg::MaxExtent : e;
  endfunction

  function automatic tu3_pkg::value_t pick_value();
    case ($urandom_range(0, 5))
      0: return tu3_pkg::value_t'(32'h7FFF_FFFF);
      1: return tu3_pkg::value_t'(32'h8000_0000);
      2: return tu3_pkg::value_t'(int'($urandom_range(0, 511)) - 256);
      default: return tu3_pkg::value_t'($urandom);
    endcase
  endfunction

  task automatic go_quiet();
    in_valid <= 1'b0;
  endtask

  task automatic drive_item(input tu3_pkg::op_t op,
                            input logic [tu3_pkg::CoordBits-1:0] px,
                            input logic [tu3_pkg::CoordBits-1:0] py,
                            input logic [tu3_pkg::CoordBits-1:0] pz,
                            input tu3_pkg::value_t val,
                            input logic [tu3_pkg::ChildBits-1:0] cx,
                            input logic [tu3_pkg::ChildBits-1:0] cy,
                            input logic [tu3_pkg::ChildBits-1:0] cz);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= 1'(op);
    if (op == tu3_pkg::OP_WRITE) begin
      parent_x <= px;
      parent_y <= py;
      parent_z <= pz;
      parent_value <= val;
      child_x <= tu3_pkg::ChildBits'($urandom);
      child_y <= tu3_pkg::ChildBits'($urandom);
      child_z <= tu3_pkg::ChildBits'($urandom);
    end else begin
      parent_x <= tu3_pkg::CoordBits'($urandom);
      parent_y <= tu3_pkg::CoordBits'($urandom);
      parent_z <= tu3_pkg::CoordBits'($urandom);
      parent_value <= tu3_pkg::value_t'($urandom);
      child_x <= cx;
      child_y <= cy;
      child_z <= cz;
    end
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op == tu3_pkg::OP_WRITE) begin
      node_written[{pz, py, px}] = 1'b1;
    end
    items_sent++;
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int rx_pct;
    int rx_left;
    out_ready = 1'b0;
    rx_pct = 0;
    rx_left = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_left = 40;
        case ($urandom_range(0, 2))
          0: rx_pct = 0;
          1: rx_pct = 20;
          default: rx_pct = 50;
        endcase
      end
      rx_left--;
      if (stall_long && !rst) begin
        out_ready <= 1'b0;
        repeat (LongStall) @(negedge clk);
        stall_long = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && !rst && $urandom_range(0, 99) < rx_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int lim [3];
    int c [3];
    int span [3];
    int choice;
    int bad_axis;
    int phase_end;
    logic [tu3_pkg::CoordBits-1:0] nx;
    logic [tu3_pkg::CoordBits-1:0] ny;
    logic [tu3_pkg::CoordBits-1:0] nz;

    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = tu3_pkg::CfgExtentX;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = 1'(tu3_pkg::OP_WRITE);
    parent_x = '0;
    parent_y = '0;
    parent_z = '0;
    parent_value = '0;
    child_x = '0;
    child_y = '0;
    child_z = '0;
    calm = 1'b0;
    stall_long = 1'b0;
    idle_pct = 20;
    idle_cycles = 0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 8; i++) begin
      drive_item(tu3_pkg::OP_WRITE, 4'(i & 1), 4'((i >> 1) & 1), 4'((i >> 2) & 1),
                 tu3_pkg::value_t'(CornerValues[i*tu3_pkg::ValueWidth +: tu3_pkg::ValueWidth]),
                 0, 0, 0);
    end
    for (int i = 0; i < 8; i++) begin
      drive_item(tu3_pkg::OP_WRITE, 4'(14 + (i & 1)), 4'(14 + ((i >> 1) & 1)),
                 4'(14 + ((i >> 2) & 1)), tu3_pkg::value_t'(32'h7FFF_FFFF), 0, 0, 0);
    end
    drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 1, 1, 1);
    drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 2, 1, 1);
    drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 1, 2, 1);
    drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 1, 1, 2);
    drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 2, 2, 2);
    drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 30, 30, 30);
    drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 31, 31, 31);
    drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 1);
    drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 1, 31, 0);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      go_quiet();
      while (results_outstanding != 0) @(negedge clk);
      repeat (SettleCycles) @(negedge clk);
      for (int a = 0; a < 3; a++) begin
        case (phase)
          0: extent_set[a] = 1;
          1: extent_set[a] = (a == 0) ? 0 : (a == 1) ? 5 : 31;
          2: extent_set[a] = (a == 1) ? tu3_pkg::MaxExtent : a + 2;
          PhaseCount - 1: extent_set[a] = tu3_pkg::MaxExtent;
          default: extent_set[a] = $urandom_range(1, 20);
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= (a == 0) ? tu3_pkg::CfgExtentX :
                     (a == 1) ? tu3_pkg::CfgExtentY : tu3_pkg::CfgExtentZ;
        cfg_data <= tu3_pkg::ExtentBits'(extent_set[a]);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        lim[a] = eff_extent(extent_set[a]);
      end
      cfg_valid <= 1'b0;
      calm = (phase == PhaseCount - 1);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 35;
      endcase
      if (phase == 2) begin
        idle_pct = 0;
        stall_long = 1'b1;
      end
      phase_end = items_sent + ItemsPerPhase;
      while (items_sent < phase_end) begin
        choice = $urandom_range(0, 99);
        if (choice < 60 && lim[0] > 0 && lim[1] > 0 && lim[2] > 0) begin
          for (int a = 0; a < 3; a++) begin
            c[a] = $urandom_range(1, 2 * lim[a] - 1);
            span[a] = (c[a] % 2 == 0) ? 1 : 0;
          end
          for (int i = 0; i <= span[0]; i++) begin
            for (int j = 0; j <= span[1]; j++) begin
              for (int k = 0; k <= span[2]; k++) begin
                nx = 4'((c[0] - 1) / 2 + i);
                ny = 4'((c[1] - 1) / 2 + j);
                nz = 4'((c[2] - 1) / 2 + k);
                if (!node_written[{nz, ny, nx}] || $urandom_range(0, 3) == 0) begin
                  drive_item(tu3_pkg::OP_WRITE, nx, ny, nz, pick_value(), 0, 0, 0);
                end
              end
            end
          end
          drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 5'(c[0]), 5'(c[1]), 5'(c[2]));
        end else if (choice < 80) begin
          drive_item(tu3_pkg::OP_WRITE, 4'($urandom), 4'($urandom), 4'($urandom),
                     pick_value(), 0, 0, 0);
        end else begin
          for (int a = 0; a < 3; a++) begin
            c[a] = $urandom_range(0, 31);
          end
          bad_axis = $urandom_range(0, 2);
          if (2 * lim[bad_axis] <= 31 && $urandom_range(0, 1) == 1) begin
            c[bad_axis] = $urandom_range(2 * lim[bad_axis], 31);
          end else begin
            c[bad_axis] = 0;
          end
          drive_item(tu3_pkg::OP_READ, 0, 0, 0, 0, 5'(c[0]), 5'(c[1]), 5'(c[2]));
        end
      end
    end

    go_quiet();
    while (results_outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
